// ===== hw/rtl/usd_pkg.sv =====
// Shared types and constants of the UTF-8 stream decoder.
`timescale 1ns / 1ps
package usd_pkg;

   localparam int unsigned CODE_WIDTH  = 21;
   localparam int unsigned QUEUE_DEPTH = 3;

   localparam logic [CODE_WIDTH-1:0] REPLACEMENT_RESET = 21'd65533;

   localparam logic [7:0] ASCII_MAX = 8'h7F;
   localparam logic [7:0] CONT_MAX  = 8'hBF;
   localparam logic [7:0] LEAD2_MAX = 8'hDF;
   localparam logic [7:0] LEAD3_MAX = 8'hEF;
   localparam logic [7:0] LEAD4_MAX = 8'hF7;

   localparam logic [7:0] CONT_MASK  = 8'h3F;
   localparam logic [7:0] LEAD2_MASK = 8'h1F;
   localparam logic [7:0] LEAD3_MASK = 8'h0F;
   localparam logic [7:0] LEAD4_MASK = 8'h07;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_string;
   } req_type;

   typedef struct packed {
      logic [CODE_WIDTH-1:0] code_point;
      logic                  is_error;
      logic                  last_of_run;
   } rsp_type;

   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } push_type;

endpackage

// ===== hw/rtl/usd_stream_if.sv =====
// Valid/ready channel interface with a typed payload.
`timescale 1ns / 1ps
interface usd_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/usd_decode.sv =====
// Decoder state, replacement register and per-byte result logic.
`timescale 1ns / 1ps
module usd_decode (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             accept,
   input  usd_pkg::req_type                 req,
   input  logic                             csr_write_enable,
   input  logic [usd_pkg::CODE_WIDTH-1:0]   csr_write_data,
   output usd_pkg::push_type                push
);

   logic [1:0]                       pend_ff, pend_in, pend_mid;
   logic [usd_pkg::CODE_WIDTH-1:0]   acc_ff, acc_in, acc_mid;
   logic [usd_pkg::CODE_WIDTH-1:0]   repl_ff, repl_in;
   logic [7:0]                       c;
   logic [1:0]                       n;
   usd_pkg::rsp_type                 r0, r1, err, plain;

   assign c = req.data_byte;

   always_comb begin
      err.code_point  = repl_ff;
      err.is_error    = 1'b1;
      err.last_of_run = 1'b0;
      plain           = err;
      plain.is_error  = 1'b0;
      r0       = err;
      r1       = err;
      n        = 2'd0;
      pend_mid = pend_ff;
      acc_mid  = acc_ff;
      if (c <= usd_pkg::ASCII_MAX) begin
         plain.code_point = {13'd0, c};
         if (pend_ff != 2'd0) begin
            r1 = plain;
            n  = 2'd2;
         end else begin
            r0 = plain;
            n  = 2'd1;
         end
         pend_mid = 2'd0;
      end else if (c <= usd_pkg::CONT_MAX) begin
         if (pend_ff != 2'd0) begin
            acc_mid  = {acc_ff[usd_pkg::CODE_WIDTH-7:0], c[5:0] & usd_pkg::CONT_MASK[5:0]};
            pend_mid = 2'(pend_ff - 2'd1);
            if (pend_ff == 2'd1) begin
               plain.code_point = acc_mid;
               r0 = plain;
               n  = 2'd1;
            end
         end else begin
            n = 2'd1;
         end
      end else if (c <= usd_pkg::LEAD2_MAX) begin
         pend_mid = 2'd1;
         acc_mid  = {13'd0, c & usd_pkg::LEAD2_MASK};
      end else if (c <= usd_pkg::LEAD3_MAX) begin
         pend_mid = 2'd2;
         acc_mid  = {13'd0, c & usd_pkg::LEAD3_MASK};
      end else if (c <= usd_pkg::LEAD4_MAX) begin
         pend_mid = 2'd3;
         acc_mid  = {13'd0, c & usd_pkg::LEAD4_MASK};
      end else begin
         n        = 2'd1;
         pend_mid = 2'd0;
      end

      pend_in = pend_mid;
      acc_in  = acc_mid;
      if (req.end_of_string) begin
         if (pend_mid != 2'd0) begin
            if (n == 2'd0) begin
               r0 = err;
            end else begin
               r1 = err;
            end
            n = 2'(n + 2'd1);
         end
         pend_in = 2'd0;
         acc_in  = '0;
      end

      case (n)
         2'd1:    r0.last_of_run = 1'b1;
         2'd2:    r1.last_of_run = 1'b1;
         default: ;
      endcase

      push.count  = n;
      push.first  = r0;
      push.second = r1;

      repl_in = csr_write_enable ? csr_write_data : repl_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 2'd0;
         acc_ff  <= '0;
         repl_ff <= usd_pkg::REPLACEMENT_RESET;
      end else begin
         repl_ff <= repl_in;
         if (accept) begin
            pend_ff <= pend_in;
            acc_ff  <= acc_in;
         end
      end
   end

endmodule

// ===== hw/rtl/usd_queue.sv =====
// Result queue: takes up to two results per cycle, delivers one.
`timescale 1ns / 1ps
module usd_queue #(
   parameter int unsigned Depth = usd_pkg::QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   input  usd_pkg::push_type  push,
   output logic               space_ok,
   output logic               head_valid,
   output usd_pkg::rsp_type   head,
   input  logic               pop
);

   localparam int unsigned IdxW = $clog2(Depth);
   localparam int unsigned CntW = $clog2(Depth + 1);

   usd_pkg::rsp_type  ent_ff [Depth];
   usd_pkg::rsp_type  ent_in [Depth];
   logic [CntW-1:0]   cnt_ff, cnt_in, cnt_mid;
   logic [IdxW-1:0]   idx0, idx1;

   assign space_ok   = cnt_ff <= CntW'(Depth - 2);
   assign head_valid = cnt_ff != '0;
   assign head       = ent_ff[0];

   always_comb begin
      ent_in  = ent_ff;
      cnt_mid = cnt_ff;
      if (pop) begin
         for (int i = 0; i < Depth - 1; i++) begin
            ent_in[i] = ent_ff[i + 1];
         end
         cnt_mid = CntW'(cnt_ff - 1'b1);
      end
      idx0   = cnt_mid[IdxW-1:0];
      idx1   = IdxW'(idx0 + 1'b1);
      cnt_in = cnt_mid;
      if (push_valid) begin
         if (push.count != 2'd0) begin
            ent_in[idx0] = push.first;
         end
         if (push.count == 2'd2) begin
            ent_in[idx1] = push.second;
         end
         cnt_in = CntW'(cnt_mid + CntW'(push.count));
      end
   end

   always_ff @(posedge clock) begin
      ent_ff <= ent_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

endmodule

// ===== hw/rtl/utf8_stream_decoder_top.sv =====
// Top level of the UTF-8 stream decoder.
//
//   channel       direction  payload                                  transfer when
//   req_channel   in         data_byte[7:0], end_of_string            valid && ready
//   rsp_channel   out        code_point[20:0], is_error, last_of_run  valid && ready
//   csr_*         in         csr_write_data[20:0] replacement code    csr_write_enable
//
// One byte per cycle while the result queue has space; each result is registered in the queue.
// A byte that gives two results uses the single result port for both, one after the other.
// req_channel.ready comes from the result queue fill only; results queue up to Depth.
// Synchronous reset clears decoder state and the queue; no clearing pass.
`timescale 1ns / 1ps
module utf8_stream_decoder_top #(
   parameter int unsigned QueueDepth = usd_pkg::QUEUE_DEPTH
) (
   input  logic                            clock,
   input  logic                            reset,
   usd_stream_if.sink                      req_channel,
   usd_stream_if.source                    rsp_channel,
   input  logic                            csr_write_enable,
   input  logic [usd_pkg::CODE_WIDTH-1:0]  csr_write_data
);

   logic               accept;
   logic               space_ok;
   usd_pkg::push_type  push;
   usd_pkg::rsp_type   head;

   assign req_channel.ready = space_ok;
   assign accept            = req_channel.valid && space_ok;

   usd_decode u_decode (
      .clock            (clock),
      .reset            (reset),
      .accept           (accept),
      .req              (req_channel.payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .push             (push)
   );

   usd_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (accept),
      .push       (push),
      .space_ok   (space_ok),
      .head_valid (rsp_channel.valid),
      .head       (head),
      .pop        (rsp_channel.valid && rsp_channel.ready)
   );

   assign rsp_channel.payload = head;

endmodule

// ===== hw/rtl/usd_checker.sv =====
// Port-level checks of the UTF-8 stream decoder, bound to the top level.
`timescale 1ns / 1ps
module usd_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic [7:0]                      req_data_byte,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [usd_pkg::CODE_WIDTH-1:0]  rsp_code_point,
   input logic                            rsp_is_error,
   input logic                            rsp_last_of_run
);

   logic req_xfer;
   assign req_xfer = req_valid && req_ready;

   rsp_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped before transfer");

   rsp_hold_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_code_point) && $stable(rsp_is_error)
         && $stable(rsp_last_of_run))
      else $error("stalled result changed");

   reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result present after reset");

   ascii_result: assert property (@(posedge clock) disable iff (reset)
      req_xfer && (req_data_byte <= usd_pkg::ASCII_MAX) && !rsp_valid |=> rsp_valid)
      else $error("ASCII byte gave no result");

   invalid_result: assert property (@(posedge clock) disable iff (reset)
      req_xfer && (req_data_byte > usd_pkg::LEAD4_MAX) && !rsp_valid
         |=> rsp_valid && rsp_is_error && rsp_last_of_run)
      else $error("invalid byte gave no single error result");

endmodule

bind utf8_stream_decoder_top usd_checker u_usd_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_channel.valid),
   .req_ready       (req_channel.ready),
   .req_data_byte   (req_channel.payload.data_byte),
   .rsp_valid       (rsp_channel.valid),
   .rsp_ready       (rsp_channel.ready),
   .rsp_code_point  (rsp_channel.payload.code_point),
   .rsp_is_error    (rsp_channel.payload.is_error),
   .rsp_last_of_run (rsp_channel.payload.last_of_run)
);

// ===== sim/usd_decode_checker.sv =====
// Checker for the UTF-8 stream decoder: predicts results from byte transfers and compares them.
`timescale 1ns / 1ps
module usd_decode_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_ready,
   input  usd_pkg::req_type               req_payload,
   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  usd_pkg::rsp_type               rsp_payload,
   input  logic                           csr_write_enable,
   input  logic [usd_pkg::CODE_WIDTH-1:0] csr_write_data,
   output int unsigned                    fail_count,
   output int unsigned                    outstanding
);

   logic [1:0]                     open_count;
   logic [usd_pkg::CODE_WIDTH-1:0] partial_code;
   logic [usd_pkg::CODE_WIDTH-1:0] replacement;
   usd_pkg::rsp_type               expected_codes[$];
   int unsigned                    errors;

   function automatic usd_pkg::rsp_type make_code(input logic [usd_pkg::CODE_WIDTH-1:0] code,
                                                  input logic err);
      usd_pkg::rsp_type r;
      r.code_point  = code;
      r.is_error    = err;
      r.last_of_run = 1'b0;
      return r;
   endfunction

   task automatic decode_byte(input usd_pkg::req_type item);
      logic [7:0]       b;
      usd_pkg::rsp_type slot [0:1];
      int               n;
      int               i;
      b = item.data_byte;
      n = 0;
      if (b <= usd_pkg::ASCII_MAX) begin
         if (open_count != 0) begin
            slot[n] = make_code(replacement, 1'b1);
            n++;
            open_count = 2'd0;
         end
         slot[n] = make_code({13'd0, b}, 1'b0);
         n++;
      end else if (b <= usd_pkg::CONT_MAX) begin
         if (open_count != 0) begin
            partial_code = {partial_code[usd_pkg::CODE_WIDTH-7:0],
                            6'(b & usd_pkg::CONT_MASK)};
            open_count   = open_count - 2'd1;
            if (open_count == 0) begin
               slot[n] = make_code(partial_code, 1'b0);
               n++;
            end
         end else begin
            slot[n] = make_code(replacement, 1'b1);
            n++;
         end
      end else if (b <= usd_pkg::LEAD2_MAX) begin
         open_count   = 2'd1;
         partial_code = {13'd0, b & usd_pkg::LEAD2_MASK};
      end else if (b <= usd_pkg::LEAD3_MAX) begin
         open_count   = 2'd2;
         partial_code = {13'd0, b & usd_pkg::LEAD3_MASK};
      end else if (b <= usd_pkg::LEAD4_MAX) begin
         open_count   = 2'd3;
         partial_code = {13'd0, b & usd_pkg::LEAD4_MASK};
      end else begin
         slot[n] = make_code(replacement, 1'b1);
         n++;
         open_count = 2'd0;
      end

      if (item.end_of_string) begin
         if (open_count != 0) begin
            slot[n] = make_code(replacement, 1'b1);
            n++;
         end
         open_count   = 2'd0;
         partial_code = '0;
      end

      if (n > 0) slot[n-1].last_of_run = 1'b1;
      for (i = 0; i < n; i++) expected_codes = {expected_codes, slot[i]};
   endtask

   always @(posedge clock) begin : monitor
      usd_pkg::rsp_type want;
      if (reset) begin
         open_count   = 2'd0;
         partial_code = '0;
         replacement  = usd_pkg::REPLACEMENT_RESET;
         errors       = 0;
         expected_codes.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_codes.size() == 0) begin
               $display("%0t: result with none expected: code_point %h is_error %b last_of_run %b",
                        $time, rsp_payload.code_point, rsp_payload.is_error,
                        rsp_payload.last_of_run);
               errors++;
            end else begin
               want = expected_codes.pop_front();
               if (rsp_payload.code_point !== want.code_point) begin
                  $display("%0t: code_point expected %h actual %h",
                           $time, want.code_point, rsp_payload.code_point);
                  errors++;
               end
               if (rsp_payload.is_error !== want.is_error) begin
                  $display("%0t: is_error expected %b actual %b",
                           $time, want.is_error, rsp_payload.is_error);
                  errors++;
               end
               if (rsp_payload.last_of_run !== want.last_of_run) begin
                  $display("%0t: last_of_run expected %b actual %b",
                           $time, want.last_of_run, rsp_payload.last_of_run);
                  errors++;
               end
            end
         end
         if (req_valid && req_ready) decode_byte(req_payload);
         if (csr_write_enable) replacement = csr_write_data;
      end
      fail_count  <= errors;
      outstanding <= expected_codes.size();
   end

endmodule

// ===== sim/utf8_stream_decoder_top_test.sv =====
// Testbench top for the UTF-8 stream decoder: byte stimulus, result stalls and the verdict.
`timescale 1ns / 1ps
module utf8_stream_decoder_top_test;

   localparam int unsigned LONG_HOLD      = 160;
   localparam int unsigned WATCHDOG_LIMIT = 2000;
   localparam int unsigned PHASE_BYTES    = 350;
   localparam int unsigned PHASES         = 4;

   typedef enum int unsigned {
      TAIL_WHOLE,
      TAIL_ASCII,
      TAIL_LEAD,
      TAIL_INVALID,
      TAIL_STRING
   } tail_kind;

   logic                           clock;
   logic                           reset;
   logic                           csr_write_enable;
   logic [usd_pkg::CODE_WIDTH-1:0] csr_write_data;
   int unsigned                    fail_count;
   int unsigned                    outstanding;
   int unsigned                    byte_count = 0;
   int unsigned                    idle_cycles = 0;
   int unsigned                    long_holds_requested = 0;
   int unsigned                    long_holds_done = 0;
   bit                             allow_idle = 1'b0;

   usd_stream_if #(.payload_type(usd_pkg::req_type)) req_bus ();
   usd_stream_if #(.payload_type(usd_pkg::rsp_type)) rsp_bus ();

   utf8_stream_decoder_top u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_channel      (req_bus),
      .rsp_channel      (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   usd_decode_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_bus.valid),
      .req_ready        (req_bus.ready),
      .req_payload      (req_bus.payload),
      .rsp_valid        (rsp_bus.valid),
      .rsp_ready        (rsp_bus.ready),
      .rsp_payload      (rsp_bus.payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .fail_count       (fail_count),
      .outstanding      (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : result_sink
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (long_holds_done < long_holds_requested) begin
            rsp_bus.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            long_holds_done++;
         end else if (allow_idle && $urandom_range(0, 9) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clock);
         end else begin
            rsp_bus.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic eos);
      usd_pkg::req_type item;
      item.data_byte     = b;
      item.end_of_string = eos;
      if (allow_idle && $urandom_range(0, 7) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.payload <= item;
      do @(posedge clock); while (!req_bus.ready);
      byte_count++;
   endtask

   task automatic drain_results();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_replacement(input logic [usd_pkg::CODE_WIDTH-1:0] code);
      drain_results();
      csr_write_enable <= 1'b1;
      csr_write_data   <= code;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   function automatic logic pick_eos(input bit at_boundary);
      return at_boundary ? ($urandom_range(0, 5) == 0) : ($urandom_range(0, 63) == 0);
   endfunction

   task automatic send_random_unit();
      int unsigned kind;
      int unsigned conts;
      int unsigned sent;
      int unsigned i;
      logic [7:0]  lead;
      logic        eos;
      tail_kind    tail;
      kind = $urandom_range(0, 99);
      if (kind < 30) begin
         send_byte(8'($urandom_range(0, usd_pkg::ASCII_MAX)), pick_eos(1'b1));
      end else if (kind < 75 || (kind >= 87 && kind < 94)) begin
         conts = $urandom_range(1, 3);
         case (conts)
            1: lead = 8'($urandom_range(usd_pkg::CONT_MAX + 1, usd_pkg::LEAD2_MAX));
            2: lead = 8'($urandom_range(usd_pkg::LEAD2_MAX + 1, usd_pkg::LEAD3_MAX));
            default: lead = 8'($urandom_range(usd_pkg::LEAD3_MAX + 1, usd_pkg::LEAD4_MAX));
         endcase
         if (kind < 75) begin
            tail = TAIL_WHOLE;
            sent = conts;
         end else begin
            tail = tail_kind'($urandom_range(TAIL_ASCII, TAIL_STRING));
            sent = $urandom_range(0, conts - 1);
         end
         send_byte(lead, (sent == 0 && tail == TAIL_STRING) ? 1'b1 : pick_eos(1'b0));
         for (i = 0; i < sent; i++) begin
            if (i + 1 < sent) eos = pick_eos(1'b0);
            else if (tail == TAIL_STRING) eos = 1'b1;
            else eos = pick_eos(tail == TAIL_WHOLE);
            send_byte(8'($urandom_range(usd_pkg::CONT_MAX - usd_pkg::CONT_MASK,
                                        usd_pkg::CONT_MAX)), eos);
         end
         case (tail)
            TAIL_ASCII: begin
               send_byte(8'($urandom_range(0, usd_pkg::ASCII_MAX)), pick_eos(1'b1));
            end
            TAIL_LEAD: begin
               send_byte(8'($urandom_range(usd_pkg::CONT_MAX + 1, usd_pkg::LEAD4_MAX)),
                         pick_eos(1'b0));
            end
            TAIL_INVALID: begin
               send_byte(8'($urandom_range(usd_pkg::LEAD4_MAX + 1, 8'hFF)), pick_eos(1'b1));
            end
            default: ;
         endcase
      end else if (kind < 82) begin
         send_byte(8'($urandom_range(usd_pkg::ASCII_MAX + 1, usd_pkg::CONT_MAX)),
                   pick_eos(1'b1));
      end else if (kind < 87) begin
         send_byte(8'($urandom_range(usd_pkg::LEAD4_MAX + 1, 8'hFF)), pick_eos(1'b1));
      end else begin
         send_byte(8'($urandom), pick_eos(1'b1));
      end
   endtask

   initial begin : stimulus
      logic [8:0]  directed_bytes [0:24] = '{
         9'h000, 9'h07F, 9'h0C2, 9'h0A9, 9'h0DF, 9'h0BF, 9'h0E2, 9'h082, 9'h1AC,
         9'h0F7, 9'h0BF, 9'h0BF, 9'h0BF, 9'h080, 9'h0FF, 9'h0C3, 9'h041, 9'h0E2,
         9'h0C3, 9'h0A9, 9'h0F0, 9'h19F, 9'h0C3, 9'h141, 9'h1F8
      };
      int unsigned phase;
      int unsigned target;
      int unsigned i;

      req_bus.valid    <= 1'b0;
      req_bus.payload  <= '0;
      csr_write_enable <= 1'b0;
      csr_write_data   <= '0;
      reset            <= 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      allow_idle = 1'b1;
      for (i = 0; i < 25; i++) send_byte(directed_bytes[i][7:0], directed_bytes[i][8]);

      for (phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: write_replacement('0);
            1: write_replacement('1);
            2: write_replacement(usd_pkg::CODE_WIDTH'($urandom_range(0, 2097151)));
            default: write_replacement(usd_pkg::REPLACEMENT_RESET);
         endcase
         allow_idle = (phase + 1 < PHASES);
         if (phase == 1) long_holds_requested++;
         target = byte_count + PHASE_BYTES;
         while (byte_count < target) begin
            if (phase + 1 < PHASES) allow_idle = ((byte_count / 64) % 3) != 2;
            send_random_unit();
         end
      end

      drain_results();
      if (fail_count == 0 && outstanding == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
